// File: design/wildcard_byte_pattern_scanner_defines.svh
// Assertion macros for the wildcard byte pattern scanner.
// Users need signals named clk and rst_n in scope.
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_DEFINES_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define WBPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wbps assertion failed");
// checked during reset too
`define WBPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wbps assertion failed");
`else
`define WBPS_ASSERT(lbl, prop)
`define WBPS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: design/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// No dependencies.
package wbps_pkg;

  localparam int LEN_LIMIT = 512;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_BASE    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MATCH_OFFSET   = 2'd2;

  localparam logic ACT_WRITE_ENTRY = 1'b0;
  localparam logic ACT_SCAN        = 1'b1;

  typedef struct packed {
    logic       action;
    logic [5:0] entry_index;
    logic [7:0] entry_byte;
    logic       entry_wildcard;
    logic [7:0] scan_byte;
    logic       region_end;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] match_address;
  } out_item_t;

  // per-cycle control broadcast down the cell chain
  typedef struct packed {
    logic scan;
    logic clear;
  } cell_ctl_t;

  // report request handed to the output pipeline
  typedef struct packed {
    logic        found;
    logic [63:0] start;
  } rpt_req_t;

endpackage

// File: design/wbps_cell.sv
// One pattern position: stored byte, wildcard bit and partial-match bit.
// Depends on wbps_pkg.
module wbps_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [7:0]          wr_byte,
  input  logic                wr_wild,
  input  wbps_pkg::cell_ctl_t ctl,
  input  logic                active,
  input  logic                prev_in,
  input  logic [7:0]          scan_byte,
  output logic                match_nxt,
  output logic                match_q
);

  logic [7:0] byte_r;
  logic       wild_r;
  logic       match_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_r <= wr_byte;
      wild_r <= wr_wild;
    end
  end

  assign match_nxt = active & prev_in & (wild_r | (byte_r == scan_byte));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.scan) begin
      match_r <= ctl.clear ? 1'b0 : match_nxt;
    end
  end

  assign match_q = match_r;

endmodule

// File: design/wbps_report.sv
// Result pipeline: request stage, address add and output register.
// Depends on wbps_pkg and the assertion macro header.
`include "wildcard_byte_pattern_scanner_defines.svh"

module wbps_report (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [63:0]          region_base,
  input  logic [63:0]          match_offset,
  input  logic                 req_valid,
  input  wbps_pkg::rpt_req_t   req,
  output logic                 req_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wbps_pkg::out_item_t  out_data
);

  logic [63:0]         base_off_r;
  logic                s1_valid_r;
  wbps_pkg::rpt_req_t  s1_req_r;
  logic                out_valid_r;
  wbps_pkg::out_item_t out_data_r;
  wbps_pkg::out_item_t out_data_nxt;
  logic                s1_go;

  // base + offset is registered from the region base and match offset inputs
  always_ff @(posedge clk) begin
    base_off_r <= region_base + match_offset;
  end

  assign s1_go     = s1_valid_r & (~out_valid_r | out_ready);
  assign req_ready = ~s1_valid_r | s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (req_ready) begin
      s1_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_req_r <= req;
    end
  end

  always_comb begin
    out_data_nxt.found         = s1_req_r.found;
    out_data_nxt.match_address = s1_req_r.found ? (base_off_r + s1_req_r.start) : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WBPS_ASSERT(a_notfound_zero, out_valid_r && !out_data_r.found |-> out_data_r.match_address == 64'd0)
  `WBPS_ASSERT(a_req_not_dropped, req_valid |-> req_ready)
  `WBPS_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r && !s1_valid_r)
  `WBPS_ASSERT(a_out_hold, out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))

endmodule

// File: design/wildcard_byte_pattern_scanner.sv
// Wildcard byte pattern scanner, top level.
// Depends on wbps_pkg, wbps_cell, wbps_report and the assertion macro header.
//
// Usage:
//   cfg_*  : register writes (0 pattern_length, 1 region_base, 2 match_offset).
//            Write only while no scan is in flight. cfg_ready is always high;
//            a pending cfg request holds off in_ready for that cycle.
//   in_*   : action 0 loads one pattern entry, action 1 presents one region
//            byte; region_end marks the last byte of the region.
//   out_*  : at most one result per region: found (only with nonzero base) with the match address
//            (base + start + offset, mod 2^64) at the first full match, or
//            not-found with address zero on the last byte when none matched.
// Throughput: one request per cycle while in_ready is high. The cell chain compares the byte in
//   every position at once and shifts the partial-match bits one cell.
// Path: the request stage loads at the accepting edge; the address add then
//   lands in the output register once that register is empty or being read.
// Reset: config registers, the match chain, the byte counter and the
//   reported flag clear; pattern entries stay undefined until written.
// Stall: the request stage and output register hold up to two results; in_ready
//   drops when both are full and out_ready is low, or while cfg_valid is high.
`include "wildcard_byte_pattern_scanner_defines.svh"

module wildcard_byte_pattern_scanner #(
  parameter int PATTERN_MAX   = 64,
  parameter int POSITION_BITS = 40
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [63:0]                          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  wbps_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output wbps_pkg::out_item_t                  out_data
);

  logic [6:0]               pat_len_r;
  logic [63:0]              region_base_r;
  logic [63:0]              match_offset_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic                     reported_r;
  logic                     reported_nxt;

  logic                     cfg_fire;
  logic                     in_fire;
  logic                     scan_fire;
  logic                     wr_fire;
  logic                     usable;
  logic [6:0]               len_eff;
  logic                     hit;
  logic                     found_now;
  logic                     last;
  logic                     rpt_ready;
  logic                     rpt_valid;
  wbps_pkg::rpt_req_t       rpt_req;
  wbps_pkg::cell_ctl_t      ctl;
  logic [POSITION_BITS-1:0] start;

  logic [PATTERN_MAX-1:0]   match_nxt;
  logic [PATTERN_MAX-1:0]   match_q;
  logic [PATTERN_MAX-1:0]   tail_hit;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_ready  = ~cfg_valid & rpt_ready;
  assign in_fire   = in_valid & in_ready;
  assign scan_fire = in_fire & (in_data.action == wbps_pkg::ACT_SCAN);
  assign wr_fire   = in_fire & (in_data.action == wbps_pkg::ACT_WRITE_ENTRY);
  assign last      = in_data.region_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r      <= 7'd0;
      region_base_r  <= 64'd0;
      match_offset_r <= 64'd0;
    end else if (cfg_fire) begin
      case (cfg_index)
        wbps_pkg::CFG_PATTERN_LENGTH: pat_len_r      <= cfg_data[6:0];
        wbps_pkg::CFG_REGION_BASE:    region_base_r  <= cfg_data;
        wbps_pkg::CFG_MATCH_OFFSET:   match_offset_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign usable  = (pat_len_r != 7'd0) && (32'(pat_len_r) <= PATTERN_MAX) &&
                   (32'(pat_len_r) < wbps_pkg::LEN_LIMIT);
  assign len_eff = usable ? pat_len_r : 7'd0;

  assign ctl.scan  = scan_fire;
  assign ctl.clear = last;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic prev;
    logic wr_sel;
    if (j == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = match_q[j-1];
    end
    assign wr_sel      = wr_fire && (32'(in_data.entry_index) == j);
    assign tail_hit[j] = match_nxt[j] && (32'(len_eff) == j + 1);

    wbps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (wr_sel),
      .wr_byte   (in_data.entry_byte),
      .wr_wild   (in_data.entry_wildcard),
      .ctl       (ctl),
      .active    (32'(len_eff) > j),
      .prev_in   (prev),
      .scan_byte (in_data.scan_byte),
      .match_nxt (match_nxt[j]),
      .match_q   (match_q[j])
    );
  end

  assign hit       = |tail_hit;
  assign found_now = hit && (region_base_r != 64'd0) && !reported_r;
  assign start     = pos_r - POSITION_BITS'(len_eff) + POSITION_BITS'(1);

  always_comb begin
    pos_nxt      = pos_r;
    reported_nxt = reported_r;
    if (scan_fire) begin
      if (last) begin
        pos_nxt      = '0;
        reported_nxt = 1'b0;
      end else begin
        pos_nxt      = pos_r + POSITION_BITS'(1);
        reported_nxt = reported_r | found_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      reported_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      reported_r <= reported_nxt;
    end
  end

  assign rpt_valid     = scan_fire && (found_now || (last && !reported_r));
  assign rpt_req.found = found_now;
  assign rpt_req.start = 64'(start);

  wbps_report u_report (
    .clk          (clk),
    .rst_n        (rst_n),
    .region_base  (region_base_r),
    .match_offset (match_offset_r),
    .req_valid    (rpt_valid),
    .req          (rpt_req),
    .req_ready    (rpt_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  `WBPS_ASSERT(a_cfg_scan_apart, !(cfg_fire && in_fire))
  `WBPS_ASSERT(a_end_clears, scan_fire && last |=> pos_r == '0 && !reported_r && match_q == '0)
  `WBPS_ASSERT(a_no_hit_zero_base, region_base_r == 64'd0 |-> !found_now)
  `WBPS_ASSERT(a_one_result, rpt_valid && !last |=> !(rpt_valid && rpt_req.found))

endmodule

// File: test/wildcard_byte_pattern_scanner_tb.sv
// Self-checking testbench for wildcard_byte_pattern_scanner: directed corner cases, then
// random regions with planted, cut-short and noisy patterns, under random handshake stalls.
// Depends on wbps_pkg and the scanner RTL only.
module wildcard_byte_pattern_scanner_tb;

  localparam int PAT_MAX        = 64;
  localparam int POS_BITS       = 40;
  localparam int CLK_PERIOD     = 8;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 150;
  localparam int TIMEOUT_CYCLES = 1500000;
  localparam logic [wbps_pkg::CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [wbps_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid;
  logic in_ready;
  wbps_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  wbps_pkg::out_item_t out_data;

  // Tracks pattern store, shift-and vector and byte counter; queues the reports they imply.
  class signature_scoreboard;
    logic [7:0] pat_byte [PAT_MAX];
    logic pat_wild [PAT_MAX];
    logic [PAT_MAX-1:0] live;
    logic [POS_BITS-1:0] pos;
    bit reported;
    logic [6:0] pat_len;
    logic [63:0] base;
    logic [63:0] offset;
    wbps_pkg::out_item_t pending_reports[$];
    int errors;
    int checked;
    int hits;
    int misses;

    function new();
      live = '0;
      pos = '0;
      reported = 1'b0;
      pat_len = '0;
      base = '0;
      offset = '0;
      errors = 0;
      checked = 0;
      hits = 0;
      misses = 0;
    endfunction

    function void apply_config(logic [wbps_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] data);
      case (idx)
        wbps_pkg::CFG_PATTERN_LENGTH: pat_len = data[6:0];
        wbps_pkg::CFG_REGION_BASE:    base = data;
        wbps_pkg::CFG_MATCH_OFFSET:   offset = data;
        default: ;
      endcase
    endfunction

    function void apply_request(wbps_pkg::in_item_t it);
      logic [PAT_MAX-1:0] nxt;
      logic [POS_BITS-1:0] start;
      wbps_pkg::out_item_t rpt;
      int len;
      int j;
      bit usable;
      bit prev;
      if (it.action == wbps_pkg::ACT_WRITE_ENTRY) begin
        pat_byte[it.entry_index] = it.entry_byte;
        pat_wild[it.entry_index] = it.entry_wildcard;
        return;
      end
      usable = pat_len != 0 && pat_len <= PAT_MAX && pat_len < wbps_pkg::LEN_LIMIT;
      len = usable ? int'(pat_len) : 0;
      nxt = '0;
      for (j = 0; j < len; j++) begin
        prev = (j == 0) ? 1'b1 : live[j-1];
        if (prev && (pat_wild[j] || pat_byte[j] == it.scan_byte)) nxt[j] = 1'b1;
      end
      live = nxt;
      if (len != 0 && live[len-1] && base != 0 && !reported) begin
        start = pos - POS_BITS'(len - 1);
        rpt.found = 1'b1;
        rpt.match_address = base + 64'(start) + offset;
        pending_reports.push_back(rpt);
        reported = 1'b1;
      end
      pos = pos + 1'b1;
      if (it.region_end) begin
        if (!reported) begin
          rpt.found = 1'b0;
          rpt.match_address = '0;
          pending_reports.push_back(rpt);
        end
        live = '0;
        pos = '0;
        reported = 1'b0;
      end
    endfunction

    function void check_report(wbps_pkg::out_item_t got);
      wbps_pkg::out_item_t want;
      checked++;
      if (pending_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected report found=%0b addr=%h with none pending",
                   got.found, got.match_address);
        return;
      end
      want = pending_reports.pop_front();
      if (want.found) hits++;
      else misses++;
      if (got.found !== want.found || got.match_address !== want.match_address) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: report %0d expected found=%0b addr=%h, got found=%0b addr=%h",
                   checked, want.found, want.match_address, got.found, got.match_address);
      end
    endfunction

    function int reports_pending();
      return pending_reports.size();
    endfunction
  endclass

  signature_scoreboard sb;

  // driver-side copy of the pattern, used only to shape stimulus
  logic [7:0] pat_b [PAT_MAX];
  logic pat_w [PAT_MAX];
  bit written [PAT_MAX];

  int items_sent;
  int entry_writes;
  int scan_bytes;
  int regions;
  int settings;
  int max_len;
  bit quiet;
  bit long_hold;
  bit holding;

  wildcard_byte_pattern_scanner #(
    .PATTERN_MAX  (PAT_MAX),
    .POSITION_BITS(POS_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_report(out_data);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pattern_byte_at(int k);
    return pat_w[k] ? 8'($urandom) : pat_b[k];
  endfunction

  // background bytes lean on pattern bytes so partial matches keep forming
  function automatic logic [7:0] filler_byte(int eff);
    if (eff != 0 && $urandom_range(0, 1) == 0) return pat_b[$urandom_range(0, eff - 1)];
    return 8'($urandom);
  endfunction

  task automatic send_item(input wbps_pkg::in_item_t it);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.apply_request(it);
    items_sent++;
  endtask

  task automatic write_entry(input int idx, input logic [7:0] b, input logic w,
                             input logic last);
    wbps_pkg::in_item_t it;
    it.action = wbps_pkg::ACT_WRITE_ENTRY;
    it.entry_index = 6'(idx);
    it.entry_byte = b;
    it.entry_wildcard = w;
    it.scan_byte = 8'($urandom);
    it.region_end = last;
    send_item(it);
    pat_b[idx] = b;
    pat_w[idx] = w;
    written[idx] = 1'b1;
    entry_writes++;
  endtask

  task automatic send_scan(input logic [7:0] b, input logic last);
    wbps_pkg::in_item_t it;
    it.action = wbps_pkg::ACT_SCAN;
    it.entry_index = 6'($urandom);
    it.entry_byte = 8'($urandom);
    it.entry_wildcard = 1'($urandom);
    it.scan_byte = b;
    it.region_end = last;
    send_item(it);
    scan_bytes++;
    if (last) regions++;
  endtask

  task automatic write_cfg(input logic [wbps_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_config(idx, data);
  endtask

  // registers only change once the scanner has nothing in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.reports_pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic scan_region(input int eff);
    logic [7:0] seq [$];
    int span;
    int at;
    int cut;
    int k;
    if (eff > 8) span = $urandom_range(eff, eff + 40);
    else span = $urandom_range(1, 30);
    for (k = 0; k < span; k++) seq.push_back(filler_byte(eff));
    if (eff != 0 && span >= eff && $urandom_range(0, 3) != 0) begin
      at = $urandom_range(0, span - eff);
      for (k = 0; k < eff; k++) seq[at + k] = pattern_byte_at(k);
    end else if (eff > 1 && span >= eff - 1) begin
      // pattern prefix running into the region end: must not complete next region
      cut = $urandom_range(1, eff - 1);
      for (k = 0; k < cut; k++) seq[span - cut + k] = pattern_byte_at(k);
    end
    for (k = 0; k < span; k++) begin
      if ($urandom_range(0, 24) == 0)
        write_entry($urandom_range(0, PAT_MAX - 1), 8'($urandom), $urandom_range(0, 3) == 0,
                    1'($urandom));
      send_scan(seq[k], k == span - 1);
    end
  endtask

  task automatic random_phase();
    logic [6:0] len;
    logic [63:0] word;
    int r;
    int eff;
    int i;
    wait_idle();
    quiet = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 19);
    if (r == 0) len = 7'd0;
    else if (r == 1) len = 7'd64;
    else if (r == 2) len = 7'($urandom_range(65, 127));
    else if (r < 6) len = 7'd1;
    else len = 7'($urandom_range(2, 8));
    word = 64'(len);
    if ($urandom_range(0, 7) == 0) word[63:7] = 57'({$urandom, $urandom});
    write_cfg(wbps_pkg::CFG_PATTERN_LENGTH, word);
    r = $urandom_range(0, 9);
    if (r == 0) word = '0;
    else if (r == 1) word = '1;
    else if (r == 2) word = 64'($urandom_range(1, 16));
    else word = {$urandom, $urandom};
    write_cfg(wbps_pkg::CFG_REGION_BASE, word);
    r = $urandom_range(0, 9);
    if (r < 3) word = '0;
    else if (r == 3) word = '1;
    else word = {$urandom, $urandom};
    write_cfg(wbps_pkg::CFG_MATCH_OFFSET, word);
    if ($urandom_range(0, 7) == 0) write_cfg(CFG_SPARE, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    settings++;
    eff = (len <= PAT_MAX) ? int'(len) : 0;
    if (eff > max_len) max_len = eff;
    for (i = 0; i < eff; i++) begin
      if (!written[i])
        write_entry(i, 8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
    end
    repeat ($urandom_range(0, 3))
      write_entry($urandom_range(0, PAT_MAX - 1), 8'($urandom), $urandom_range(0, 3) == 0,
                  1'($urandom));
    repeat ($urandom_range(1, 4)) scan_region(eff);
  endtask

  // one-byte regions each yield a report while the receiver holds off
  task automatic backpressure_phase();
    wait_idle();
    write_cfg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd1);
    write_cfg(wbps_pkg::CFG_REGION_BASE, {$urandom, $urandom} | 64'd1);
    write_cfg(wbps_pkg::CFG_MATCH_OFFSET, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    settings++;
    long_hold = 1'b1;
    wait (holding);
    quiet = 1'b1;
    repeat (24) send_scan($urandom_range(0, 1) ? pattern_byte_at(0) : 8'($urandom), 1'b1);
    quiet = 1'b0;
  endtask

  initial begin : receiver
    out_ready = 1'b0;
    holding = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
        holding = 1'b0;
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("ERROR: timeout, %0d reports still pending", sb.reports_pending());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int target;
    int phase;
    int k;
    sb = new();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    items_sent = 0;
    entry_writes = 0;
    scan_bytes = 0;
    regions = 0;
    settings = 0;
    max_len = 0;
    quiet = 1'b0;
    long_hold = 1'b0;
    for (k = 0; k < PAT_MAX; k++) begin
      pat_b[k] = '0;
      pat_w[k] = 1'b0;
      written[k] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero length: never matches, end of region reports not-found
    write_cfg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd0);
    write_cfg(wbps_pkg::CFG_REGION_BASE, 64'h1000);
    write_cfg(wbps_pkg::CFG_MATCH_OFFSET, 64'd0);
    cfg_valid <= 1'b0;
    settings++;
    send_scan(8'h00, 1'b0);
    send_scan(8'hff, 1'b1);
    // 0xff is a plain byte unless the wildcard bit is set; entry write ignores region_end
    write_entry(0, 8'h00, 1'b0, 1'b0);
    write_entry(1, 8'hff, 1'b0, 1'b0);
    write_entry(2, 8'h5a, 1'b1, 1'b0);
    write_entry(3, 8'ha5, 1'b0, 1'b0);
    write_entry(63, 8'hff, 1'b1, 1'b1);
    wait_idle();
    // address sum wraps; second match in the region stays silent
    write_cfg(wbps_pkg::CFG_PATTERN_LENGTH, 64'd4);
    write_cfg(wbps_pkg::CFG_REGION_BASE, '1);
    write_cfg(wbps_pkg::CFG_MATCH_OFFSET, '1);
    cfg_valid <= 1'b0;
    settings++;
    max_len = 4;
    send_scan(8'h00, 1'b0);
    send_scan(8'hff, 1'b0);
    send_scan(8'h33, 1'b0);
    send_scan(8'ha5, 1'b0);
    send_scan(8'h00, 1'b0);
    send_scan(8'hff, 1'b0);
    send_scan(8'h11, 1'b0);
    send_scan(8'ha5, 1'b0);
    send_scan(8'h00, 1'b1);
    // match completing on the last byte
    send_scan(8'h00, 1'b0);
    send_scan(8'hff, 1'b0);
    send_scan(8'h77, 1'b0);
    send_scan(8'ha5, 1'b1);
    // prefix cut by region end must not carry into the next region
    send_scan(8'hff, 1'b0);
    send_scan(8'h00, 1'b0);
    send_scan(8'hff, 1'b1);
    send_scan(8'h5a, 1'b0);
    send_scan(8'ha5, 1'b1);
    wait_idle();
    // zero base forces not-found
    write_cfg(wbps_pkg::CFG_REGION_BASE, 64'd0);
    write_cfg(CFG_SPARE, '1);
    cfg_valid <= 1'b0;
    settings++;
    send_scan(8'h00, 1'b0);
    send_scan(8'hff, 1'b0);
    send_scan(8'h00, 1'b0);
    send_scan(8'ha5, 1'b1);

    target = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < target) begin
      random_phase();
      phase++;
      if (phase == 8) backpressure_phase();
    end

    in_valid <= 1'b0;
    for (k = 0; k < 20000 && sb.reports_pending() != 0; k++) @(posedge clk);
    repeat (DRAIN_CYCLES + 4) @(posedge clk);
    if (sb.reports_pending() != 0)
      $display("ERROR: %0d expected reports never arrived", sb.reports_pending());
    $display("Sent %0d requests: %0d pattern writes, %0d bytes in %0d regions, %0d settings",
             items_sent, entry_writes, scan_bytes, regions, settings);
    $display("Checked %0d reports (%0d found, %0d not-found), longest pattern %0d, %0d errors",
             sb.checked, sb.hits, sb.misses, max_len, sb.errors);
    if (sb.errors == 0 && sb.reports_pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
